// ----- design/multicast_group_hash_filter_assert.svh -----
// assertion macros for the hash filter design file
`ifndef MULTICAST_GROUP_HASH_FILTER_ASSERT_SVH
`define MULTICAST_GROUP_HASH_FILTER_ASSERT_SVH

// same-cycle implication
`define MGHF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MGHF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mghf_pkg.sv -----
`timescale 1ns / 1ps

package mghf_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_DEL = 2'd1
  } op_e;

  typedef enum logic [2:0] {
    OC_ADDED     = 3'd0,
    OC_PRESENT   = 3'd1,
    OC_FULL      = 3'd2,
    OC_DELETED   = 3'd3,
    OC_NOT_FOUND = 3'd4,
    OC_INVALID   = 3'd5
  } outcome_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_ADD_WR,
    S_ADD_CRC,
    S_DEL_WR,
    S_RB_RD,
    S_RB_CHK,
    S_RB_CRC
  } state_e;

  localparam int unsigned HashIdxW = 6;
  localparam logic [31:0] CrcPoly = 32'h04C11DB7;

  // one byte, lsb first, into an msb-first shift register
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc;
    for (int b = 0; b < 8; b++) begin
      if (c[31] ^ data[b]) begin
        c = {c[30:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

  // crc state after the fixed mac prefix 01:00:5e
  localparam logic [31:0] CrcSeed =
    crc_byte(crc_byte(crc_byte(32'hFFFFFFFF, 8'h01), 8'h00), 8'h5E);

endpackage

// ----- design/mghf_ram.sv -----
`timescale 1ns / 1ps

module mghf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/mghf_crc.sv -----
`timescale 1ns / 1ps

module mghf_crc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [31:0]                   group_i,
  output logic                          done_o,
  output logic [mghf_pkg::HashIdxW-1:0] idx_o
);

  import mghf_pkg::*;

  logic        run_q;
  logic        done_q;
  logic [1:0]  step_q;
  logic [31:0] crc_q;
  logic [31:0] crc_d;
  logic [31:0] group_q;
  logic [7:0]  byte_sel;

  // mac bytes 3 to 5: b1 with the top bit masked, then b2, b3
  always_comb begin
    unique case (step_q)
      2'd0:    byte_sel = {1'b0, group_q[14:8]};
      2'd1:    byte_sel = group_q[23:16];
      default: byte_sel = group_q[31:24];
    endcase
  end

  assign crc_d = crc_byte(crc_q, byte_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= 2'd0;
      end else if (run_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd2) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      crc_q   <= CrcSeed;
      group_q <= group_i;
    end else if (run_q) begin
      crc_q <= crc_d;
    end
  end

  assign done_o = done_q;
  assign idx_o  = ~crc_q[31:32-HashIdxW];

endmodule

// ----- design/multicast_group_hash_filter.sv -----
// sequence: an invalid request is answered straight from idle; others scan the group table
// ram, one read per entry, up to a match or the last entry; an insertion then writes the entry
// and waits for the crc done flag; a delete clears the match and rescans, with a crc per occupied entry.
// throughput: one request at a time; busy is high until the result strobe, never for an invalid one.
// reset: the hash filter clears and the table reads as empty at once through per-entry valid bits.
// the result is on the ports for one cycle and cannot be stalled.
`timescale 1ns / 1ps

module multicast_group_hash_filter #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] group_address_i,
  output logic        result_valid_o,
  output logic [2:0]  outcome_o,
  output logic [31:0] hash_high_o,
  output logic [31:0] hash_low_o
);

  import mghf_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  state_e   state_q, state_d;
  op_e      op_q;
  logic [31:0] addr_q;
  logic [IdxW-1:0] cnt_q;
  logic            free_q;
  logic [IdxW-1:0] free_idx_q;
  logic [IdxW-1:0] match_idx_q;
  logic [63:0]     hash_q;
  logic [TABLE_ENTRIES-1:0] vld_q;
  logic            vld_rd_q;
  logic            done_q;
  outcome_e        outcome_q;

  logic            accept;
  logic            req_ok;
  logic [31:0]     ram_rdata;
  logic [31:0]     entry;
  logic            hit;
  logic            is_free;
  logic            last;
  logic            ram_re;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [31:0]     ram_wdata;
  logic            crc_start;
  logic [31:0]     crc_group;
  logic            crc_done;
  logic [HashIdxW-1:0] crc_idx;
  logic            fin;
  outcome_e        fin_code;
  logic            cnt_inc;
  logic            cnt_clr;
  logic            take_free;
  logic            take_match;
  logic            hash_clr;
  logic            hash_set;

  assign accept  = start && !busy;
  assign req_ok  = (opcode_i == OP_ADD) || (opcode_i == OP_DEL);
  assign entry   = ram_rdata & {32{vld_rd_q}};
  assign hit     = entry == addr_q;
  assign is_free = entry == 32'd0;
  assign last    = cnt_q == LastIdx;

  mghf_ram #(
    .Width(32),
    .Depth(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(cnt_q),
    .rdata_o(ram_rdata)
  );

  mghf_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(crc_start),
    .group_i(crc_group),
    .done_o (crc_done),
    .idx_o  (crc_idx)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && req_ok) begin
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_CHK;
      S_CHK: begin
        if (op_q == OP_DEL) begin
          if (hit) begin
            state_d = S_DEL_WR;
          end else if (last) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end else begin
          if (hit) begin
            state_d = S_IDLE;
          end else if (last) begin
            state_d = (free_q || is_free) ? S_ADD_WR : S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_ADD_WR: state_d = S_ADD_CRC;
      S_ADD_CRC: begin
        if (crc_done) begin
          state_d = S_IDLE;
        end
      end
      S_DEL_WR: state_d = S_RB_RD;
      S_RB_RD:  state_d = S_RB_CHK;
      S_RB_CHK: begin
        if (!is_free) begin
          state_d = S_RB_CRC;
        end else if (last) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_RB_RD;
        end
      end
      S_RB_CRC: begin
        if (crc_done) begin
          state_d = last ? S_IDLE : S_RB_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = free_idx_q;
    ram_wdata  = addr_q;
    crc_start  = 1'b0;
    crc_group  = addr_q;
    fin        = 1'b0;
    fin_code   = OC_INVALID;
    cnt_inc    = 1'b0;
    cnt_clr    = 1'b0;
    take_free  = 1'b0;
    take_match = 1'b0;
    hash_clr   = 1'b0;
    hash_set   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !req_ok) begin
          fin = 1'b1;
        end
      end
      S_RD: ram_re = 1'b1;
      S_CHK: begin
        if (op_q == OP_DEL) begin
          if (hit) begin
            take_match = 1'b1;
          end else if (last) begin
            fin      = 1'b1;
            fin_code = OC_NOT_FOUND;
          end else begin
            cnt_inc = 1'b1;
          end
        end else begin
          take_free = is_free && !free_q;
          if (hit) begin
            fin      = 1'b1;
            fin_code = OC_PRESENT;
          end else if (last) begin
            if (!(free_q || is_free)) begin
              fin      = 1'b1;
              fin_code = OC_FULL;
            end
          end else begin
            cnt_inc = 1'b1;
          end
        end
      end
      S_ADD_WR: begin
        ram_we    = 1'b1;
        crc_start = 1'b1;
      end
      S_ADD_CRC: begin
        if (crc_done) begin
          hash_set = 1'b1;
          fin      = 1'b1;
          fin_code = OC_ADDED;
        end
      end
      S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = match_idx_q;
        ram_wdata = 32'd0;
        hash_clr  = 1'b1;
        cnt_clr   = 1'b1;
      end
      S_RB_RD: ram_re = 1'b1;
      S_RB_CHK: begin
        crc_group = entry;
        if (!is_free) begin
          crc_start = 1'b1;
        end else if (last) begin
          fin      = 1'b1;
          fin_code = OC_DELETED;
        end else begin
          cnt_inc = 1'b1;
        end
      end
      S_RB_CRC: begin
        if (crc_done) begin
          hash_set = 1'b1;
          if (last) begin
            fin      = 1'b1;
            fin_code = OC_DELETED;
          end else begin
            cnt_inc = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      free_q    <= 1'b0;
      hash_q    <= 64'd0;
      vld_q     <= '0;
      vld_rd_q  <= 1'b0;
      done_q    <= 1'b0;
      outcome_q <= OC_INVALID;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
      if (fin) begin
        outcome_q <= fin_code;
      end
      if (accept || cnt_clr) begin
        cnt_q <= '0;
      end else if (cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (accept) begin
        free_q <= 1'b0;
      end else if (take_free) begin
        free_q <= 1'b1;
      end
      if (hash_clr) begin
        hash_q <= 64'd0;
      end else if (hash_set) begin
        hash_q <= hash_q | (64'd1 << crc_idx);
      end
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        vld_rd_q <= vld_q[cnt_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(opcode_i);
      addr_q <= group_address_i;
    end
    if (take_free) begin
      free_idx_q <= cnt_q;
    end
    if (take_match) begin
      match_idx_q <= cnt_q;
    end
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = done_q;
  assign outcome_o      = outcome_q;
  assign hash_high_o    = hash_q[63:32];
  assign hash_low_o     = hash_q[31:0];

  `include "multicast_group_hash_filter_assert.svh"

  `MGHF_ASSERT_NEXT(a_invalid_one_cycle, clk_i, rst_ni, accept && !req_ok, result_valid_o && outcome_o == OC_INVALID, "invalid request not answered next cycle")
  `MGHF_ASSERT_NOW(a_result_when_idle, clk_i, rst_ni, result_valid_o, !busy, "result transfer while busy")
  `MGHF_ASSERT_NEXT(a_delete_clears_hash, clk_i, rst_ni, state_q == S_DEL_WR, hash_q == 64'd0, "hash not cleared before rebuild")
  `MGHF_ASSERT_NOW(a_crc_done_expected, clk_i, rst_ni, crc_done, state_q == S_ADD_CRC || state_q == S_RB_CRC, "crc finished outside a hash state")
  `MGHF_ASSERT_NOW(a_no_rw_collision, clk_i, rst_ni, ram_we, !ram_re, "table read and write in the same cycle")

endmodule

// ----- tb/sv/hash_filter_checker.sv -----
`timescale 1ns / 1ps

module hash_filter_checker #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] group_address_i,
  input  logic        result_valid_o,
  input  logic [2:0]  outcome_o,
  input  logic [31:0] hash_high_o,
  input  logic [31:0] hash_low_o,
  output int          error_count_o,
  output int          pending_o,
  output int          results_o,
  output logic [5:0]  outcomes_seen_o
);

  import mghf_pkg::*;

  typedef struct packed {
    outcome_e    outcome;
    logic [63:0] filter;
  } filter_reply_t;

  logic [31:0]   groups [TABLE_ENTRIES];
  logic [63:0]   filter_bits;
  filter_reply_t awaited_replies [$];
  filter_reply_t want;
  int            errors;
  int            checked;
  logic [5:0]    seen;

  // mac 01:00:5e:(b1 & 7f):b2:b3, each byte lsb first into an msb-first register
  function automatic logic [5:0] filter_index(input logic [31:0] addr);
    logic [47:0] mac;
    logic [31:0] crc;
    mac = {addr[31:16], 1'b0, addr[14:8], 24'h5E0001};
    crc = '1;
    for (int i = 0; i < 48; i++) begin
      if (crc[31] ^ mac[i]) begin
        crc = {crc[30:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[30:0], 1'b0};
      end
    end
    crc = ~crc;
    return crc[31:26];
  endfunction

  function automatic int slot_of(input logic [31:0] addr);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (groups[i] == addr) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic outcome_e apply_request(input logic [1:0] op, input logic [31:0] addr);
    int slot;
    if (op == OP_ADD) begin
      if (slot_of(addr) >= 0) begin
        return OC_PRESENT;
      end
      slot = slot_of('0);
      if (slot < 0) begin
        return OC_FULL;
      end
      groups[slot] = addr;
      filter_bits[filter_index(addr)] = 1'b1;
      return OC_ADDED;
    end
    if (op == OP_DEL) begin
      slot = slot_of(addr);
      if (slot < 0) begin
        return OC_NOT_FOUND;
      end
      groups[slot] = '0;
      filter_bits = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (groups[i] != '0) begin
          filter_bits[filter_index(groups[i])] = 1'b1;
        end
      end
      return OC_DELETED;
    end
    return OC_INVALID;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        groups[i] = '0;
      end
      filter_bits = '0;
      awaited_replies.delete();
      errors  = 0;
      checked = 0;
      seen    = '0;
    end else begin
      if (result_valid_o) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual outcome %0d hash %h_%h",
                   $time, outcome_o, hash_high_o, hash_low_o);
          errors++;
        end else begin
          want = awaited_replies.pop_front();
          checked++;
          if (outcome_o <= 3'd5) begin
            seen[outcome_o] = 1'b1;
          end
          if (outcome_o !== want.outcome) begin
            $display("%0t: outcome mismatch, expected %0d, actual %0d",
                     $time, want.outcome, outcome_o);
            errors++;
          end
          if (hash_high_o !== want.filter[63:32]) begin
            $display("%0t: hash_high mismatch, expected %h, actual %h",
                     $time, want.filter[63:32], hash_high_o);
            errors++;
          end
          if (hash_low_o !== want.filter[31:0]) begin
            $display("%0t: hash_low mismatch, expected %h, actual %h",
                     $time, want.filter[31:0], hash_low_o);
            errors++;
          end
        end
      end
      // request transfer
      if (start && !busy) begin
        want.outcome = apply_request(opcode_i, group_address_i);
        want.filter  = filter_bits;
        awaited_replies.push_back(want);
      end
    end
    error_count_o   <= errors;
    pending_o       <= awaited_replies.size();
    results_o       <= checked;
    outcomes_seen_o <= seen;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import mghf_pkg::*;

  localparam logic [1:0] OP_RSVD_A = 2'd2;
  localparam logic [1:0] OP_RSVD_B = 2'd3;

  localparam int TableSize      = 32;
  localparam int RandomRequests = 1950;
  localparam int DrainCycles    = 400;
  localparam int CycleLimit     = 4_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  opcode_i;
  logic [31:0] group_address_i;
  logic        result_valid_o;
  logic [2:0]  outcome_o;
  logic [31:0] hash_high_o;
  logic [31:0] hash_low_o;

  int          error_count;
  int          pending;
  int          results;
  logic [5:0]  outcomes_seen;

  int          cycle_count = 0;
  int          burst_left = 0;
  int          requests_sent = 0;
  int          updates_sent = 0;
  int          random_base;
  int          kind;
  int          pick;
  logic [31:0] live_groups [$];

  initial begin
    clk_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  multicast_group_hash_filter #(
    .TABLE_ENTRIES(TableSize)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .group_address_i(group_address_i),
    .result_valid_o (result_valid_o),
    .outcome_o      (outcome_o),
    .hash_high_o    (hash_high_o),
    .hash_low_o     (hash_low_o)
  );

  hash_filter_checker #(
    .TABLE_ENTRIES(TableSize)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .group_address_i(group_address_i),
    .result_valid_o (result_valid_o),
    .outcome_o      (outcome_o),
    .hash_high_o    (hash_high_o),
    .hash_low_o     (hash_low_o),
    .error_count_o  (error_count),
    .pending_o      (pending),
    .results_o      (results),
    .outcomes_seen_o(outcomes_seen)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int live_slot(input logic [31:0] addr);
    for (int i = 0; i < live_groups.size(); i++) begin
      if (live_groups[i] == addr) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic logic [31:0] fresh_group();
    logic [31:0] addr;
    case ($urandom_range(0, 3))
      0: addr = {24'($urandom_range(0, 32'h00FF_FFFF)), 8'(224 + $urandom_range(0, 15))};
      1: addr = $urandom_range(0, 1) ? (32'h1 << $urandom_range(0, 31))
                                     : ~(32'h1 << $urandom_range(0, 31));
      default: addr = $urandom();
    endcase
    if (addr == '0) begin
      addr = 32'h1;
    end
    return addr;
  endfunction

  // one request transfer, with bursts and random gaps on the sender side
  task automatic request(input logic [1:0] op, input logic [31:0] addr);
    int gap;
    int idx;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    start           <= 1'b1;
    opcode_i        <= op;
    group_address_i <= addr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    burst_left--;
    requests_sent++;
    idx = live_slot(addr);
    if (op == OP_ADD || op == OP_DEL) begin
      updates_sent++;
    end
    if (op == OP_ADD && addr != '0 && idx < 0 && live_groups.size() < TableSize) begin
      live_groups.push_back(addr);
    end
    if (op == OP_DEL && addr != '0 && idx >= 0) begin
      live_groups.delete(idx);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    opcode_i        = OP_ADD;
    group_address_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: invalid codes, zero address, extremes, masked mac bit, rebuilds
    request(OP_RSVD_A, 32'hFFFF_FFFF);
    request(OP_RSVD_B, 32'h0000_0000);
    request(OP_ADD,    32'h0000_0000);
    request(OP_DEL,    32'h0000_0000);
    request(OP_DEL,    32'hFF00_00E0);
    request(OP_ADD,    32'hFFFF_FFFF);
    request(OP_ADD,    32'hFFFF_FFFF);
    request(OP_ADD,    32'h0000_0001);
    request(OP_ADD,    32'h0100_00E0);
    request(OP_ADD,    32'h0100_80E0);
    request(OP_ADD,    32'h7FFF_FFFF);
    request(OP_DEL,    32'h0000_0001);
    request(OP_DEL,    32'h0000_0001);
    request(OP_RSVD_A, 32'h5555_5555);
    request(OP_DEL,    32'h0100_80E0);
    request(OP_ADD,    32'h8000_0000);
    request(OP_DEL,    32'hFFFF_FFFF);
    request(OP_RSVD_B, 32'hAAAA_AAAA);
    request(OP_ADD,    32'h0000_0000);

    random_base = requests_sent;
    while (requests_sent - random_base < RandomRequests) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        // fill to capacity, then hit the full table
        while (live_groups.size() < TableSize) request(OP_ADD, fresh_group());
        request(OP_ADD, fresh_group());
        request(OP_ADD, '0);
        request(OP_DEL, '0);
        request(OP_ADD, live_groups[$urandom_range(0, TableSize - 1)]);
      end else if (kind == 2) begin
        // drain everything, with a full rebuild on each delete that hits
        while (live_groups.size() > 0) begin
          if ($urandom_range(0, 6) == 0) begin
            request(OP_DEL, fresh_group());
          end else begin
            request(OP_DEL, live_groups[$urandom_range(0, live_groups.size() - 1)]);
          end
        end
        request(OP_DEL, '0);
      end else begin
        repeat (40) begin
          pick = $urandom_range(0, 99);
          if (pick < 30) begin
            request(OP_ADD, fresh_group());
          end else if (pick < 45) begin
            request(OP_ADD, (live_groups.size() > 0)
                    ? live_groups[$urandom_range(0, live_groups.size() - 1)] : fresh_group());
          end else if (pick < 72) begin
            request(OP_DEL, (live_groups.size() > 0)
                    ? live_groups[$urandom_range(0, live_groups.size() - 1)] : fresh_group());
          end else if (pick < 82) begin
            request(OP_DEL, fresh_group());
          end else if (pick < 92) begin
            request($urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B, $urandom());
          end else begin
            request($urandom_range(0, 1) ? OP_DEL : OP_ADD, '0);
          end
        end
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d requests sent, %0d of them adds or deletes, %0d results checked",
             requests_sent, updates_sent, results);
    $display("outcome codes observed (one bit per code, added in bit 0): %b", outcomes_seen);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
